/* rtl/ksr_pkg.sv */
// Shared types and constants for the keypad scanner with repeat and key FIFO.
package ksr_pkg;

  localparam int ROWS_DEFAULT         = 2;
  localparam int COLS_DEFAULT         = 2;
  localparam int BUFFER_DEPTH_DEFAULT = 16;

  localparam int MATRIX_WIDTH = 4;
  localparam int CODE_WIDTH   = 8;
  localparam int PENDING_WIDTH = 5;
  localparam int CFG_WIDTH    = 8;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [CODE_WIDTH-1:0] EMPTY_CODE = 8'hFF;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_REPEAT_START_DELAY = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_REPEAT_DELAY       = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHIFT_ONE_OFFSET   = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHIFT_TWO_OFFSET   = 2'd3;

  localparam logic [7:0] RESET_REPEAT_START_DELAY = 8'd50;
  localparam logic [7:0] RESET_REPEAT_DELAY       = 8'd10;
  localparam logic [6:0] RESET_SHIFT_ONE_OFFSET   = 7'd4;
  localparam logic [6:0] RESET_SHIFT_TWO_OFFSET   = 7'd8;

  // item mode
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic [MATRIX_WIDTH-1:0] key_matrix;
    logic [1:0]              shift_keys;
  } req_t;

  typedef struct packed {
    logic                     read_valid;
    logic [CODE_WIDTH-1:0]    key_code;
    logic [PENDING_WIDTH-1:0] pending_count;
  } rsp_t;

endpackage

/* rtl/ksr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ksr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/keypad_scan_repeat_fifo.sv */
// Keypad scanner: debounce, auto-repeat and key-code FIFO, top level.
//
//   channel  | dir | handshake                  | payload
//   req      | in  | req_valid / req_stall      | mode, key_matrix, shift_keys
//   rsp      | out | rsp_valid / rsp_stall      | read_valid, key_code, pending_count
//   cfg      | in  | cfg_write                  | cfg_index, cfg_data
//
// One item per cycle sustained while req_stall is low; after its item is accepted,
// a result passes the code RAM read register, then the output register.
// Scan state and FIFO pointers update in the accept cycle, so items chain
// back to back; the code RAM is written and read at most once per cycle.
// Reset clears control state only; the code RAM needs no clearing pass.
// req_stall rises only when both the RAM stage and the output register are
// full and rsp_stall is high.
module keypad_scan_repeat_fifo #(
  parameter int ROWS         = ksr_pkg::ROWS_DEFAULT,
  parameter int COLS         = ksr_pkg::COLS_DEFAULT,
  parameter int BUFFER_DEPTH = ksr_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  ksr_pkg::req_t                       req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output ksr_pkg::rsp_t                       rsp,
  input  logic                                cfg_write,
  input  logic [ksr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [ksr_pkg::CFG_WIDTH-1:0]       cfg_data
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int NKEY = (ROWS * COLS < ksr_pkg::MATRIX_WIDTH) ? ROWS * COLS
                                                              : ksr_pkg::MATRIX_WIDTH;
  localparam logic [ksr_pkg::MATRIX_WIDTH-1:0] KEY_MASK =
    ksr_pkg::MATRIX_WIDTH'((1 << NKEY) - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(BUFFER_DEPTH);

  localparam logic [1:0] PHASE_UP          = 2'd0;
  localparam logic [1:0] PHASE_DEBOUNCE    = 2'd1;
  localparam logic [1:0] PHASE_START_WAIT  = 2'd2;
  localparam logic [1:0] PHASE_REPEAT_WAIT = 2'd3;

  // configuration
  logic [7:0] repeat_start_delay;
  logic [7:0] repeat_delay;
  logic [6:0] shift_one_offset;
  logic [6:0] shift_two_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_start_delay <= ksr_pkg::RESET_REPEAT_START_DELAY;
      repeat_delay       <= ksr_pkg::RESET_REPEAT_DELAY;
      shift_one_offset   <= ksr_pkg::RESET_SHIFT_ONE_OFFSET;
      shift_two_offset   <= ksr_pkg::RESET_SHIFT_TWO_OFFSET;
    end else if (cfg_write) begin
      case (cfg_index)
        ksr_pkg::REG_REPEAT_START_DELAY: repeat_start_delay <= cfg_data;
        ksr_pkg::REG_REPEAT_DELAY:       repeat_delay       <= cfg_data;
        ksr_pkg::REG_SHIFT_ONE_OFFSET:   shift_one_offset   <= cfg_data[6:0];
        ksr_pkg::REG_SHIFT_TWO_OFFSET:   shift_two_offset   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // scan and FIFO control state
  logic [1:0]    scan_phase, scan_phase_next;
  logic [7:0]    start_countdown, start_countdown_next;
  logic [7:0]    repeat_countdown, repeat_countdown_next;
  logic [AW-1:0] write_pointer, read_pointer;
  logic [CW-1:0] stored_count, stored_count_next;

  // pipeline: RAM read stage, then output register
  logic          a_valid;
  logic          a_pop;
  logic [CW-1:0] a_count;
  logic          o_valid;
  logic          o_read_valid;
  logic [7:0]    o_code;
  logic [CW-1:0] o_count;
  logic [7:0]    ram_rd_data;

  logic accept;
  logic a_move;

  assign a_move    = a_valid && (!o_valid || !rsp_stall);
  assign req_stall = a_valid && !a_move;
  assign accept    = req_valid && !req_stall;

  // key decode: lowest row with a key down, lowest column in it
  logic [ksr_pkg::MATRIX_WIDTH-1:0] matrix;
  logic       down;
  logic       found;
  logic [7:0] key_base;
  logic [7:0] key_code;

  assign matrix = req.key_matrix & KEY_MASK;
  assign down   = |matrix;

  always_comb begin
    found    = 1'b0;
    key_base = 8'd0;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        if (!found && (r * COLS + c < ksr_pkg::MATRIX_WIDTH)) begin
          if (matrix[(r * COLS + c) % ksr_pkg::MATRIX_WIDTH]) begin
            found    = 1'b1;
            key_base = 8'(r * COLS + c);
          end
        end
      end
    end
    key_code = key_base
             + (req.shift_keys[0] ? {1'b0, shift_one_offset} : 8'd0)
             + (req.shift_keys[1] ? {1'b0, shift_two_offset} : 8'd0);
  end

  logic push_req;
  logic push;
  logic pop;

  always_comb begin
    scan_phase_next       = scan_phase;
    start_countdown_next  = start_countdown;
    repeat_countdown_next = repeat_countdown;
    push_req              = 1'b0;
    case (scan_phase)
      PHASE_UP: begin
        if (down) begin
          scan_phase_next = PHASE_DEBOUNCE;
        end
      end
      PHASE_DEBOUNCE: begin
        if (down) begin
          push_req             = 1'b1;
          start_countdown_next = repeat_start_delay;
          scan_phase_next      = PHASE_START_WAIT;
        end else begin
          scan_phase_next = PHASE_UP;
        end
      end
      PHASE_START_WAIT: begin
        if (!down) begin
          scan_phase_next = PHASE_DEBOUNCE;
        end else if (start_countdown != 8'd0) begin
          start_countdown_next = start_countdown - 8'd1;
          if (start_countdown == 8'd1) begin
            push_req              = 1'b1;
            repeat_countdown_next = repeat_delay;
            scan_phase_next       = PHASE_REPEAT_WAIT;
          end
        end
      end
      default: begin
        if (!down) begin
          scan_phase_next = PHASE_DEBOUNCE;
        end else if (repeat_countdown != 8'd0) begin
          repeat_countdown_next = repeat_countdown - 8'd1;
          if (repeat_countdown == 8'd1) begin
            push_req              = 1'b1;
            repeat_countdown_next = repeat_delay;
          end
        end
      end
    endcase
  end

  assign push = accept && (req.mode == ksr_pkg::MODE_TICK) && push_req
             && (stored_count != FULL_COUNT);
  assign pop  = accept && (req.mode == ksr_pkg::MODE_READ) && (stored_count != '0);

  always_comb begin
    stored_count_next = stored_count;
    if (push) begin
      stored_count_next = stored_count + CW'(1);
    end else if (pop) begin
      stored_count_next = stored_count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase       <= PHASE_UP;
      start_countdown  <= 8'd0;
      repeat_countdown <= 8'd0;
      write_pointer    <= '0;
      read_pointer     <= '0;
      stored_count     <= '0;
    end else begin
      if (accept && (req.mode == ksr_pkg::MODE_TICK)) begin
        scan_phase       <= scan_phase_next;
        start_countdown  <= start_countdown_next;
        repeat_countdown <= repeat_countdown_next;
      end
      if (push) begin
        write_pointer <= (write_pointer == LAST_ADDR) ? '0 : write_pointer + AW'(1);
      end
      if (pop) begin
        read_pointer <= (read_pointer == LAST_ADDR) ? '0 : read_pointer + AW'(1);
      end
      stored_count <= stored_count_next;
    end
  end

  // a pop reads the RAM in the accept cycle; entries are always written in
  // an earlier cycle, so no bypass is needed
  ksr_ram #(
    .WIDTH (ksr_pkg::CODE_WIDTH),
    .DEPTH (BUFFER_DEPTH)
  ) u_code_ram (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (write_pointer),
    .wr_data (key_code),
    .rd_en   (pop),
    .rd_addr (read_pointer),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pop   <= pop;
      a_count <= stored_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (a_move) begin
      o_valid <= 1'b1;
    end else if (!rsp_stall) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      o_read_valid <= a_pop;
      o_code       <= a_pop ? ram_rd_data : ksr_pkg::EMPTY_CODE;
      o_count      <= a_count;
    end
  end

  assign rsp_valid          = o_valid;
  assign rsp.read_valid     = o_read_valid;
  assign rsp.key_code       = o_code;
  assign rsp.pending_count  = ksr_pkg::PENDING_WIDTH'(o_count);

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= FULL_COUNT)
    else $error("stored count above buffer depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    stored_count == '0 |-> write_pointer == read_pointer)
    else $error("empty buffer with unequal pointers");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    pop |=> stored_count == $past(stored_count) - CW'(1))
    else $error("pop did not decrement count");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> a_valid && o_valid && rsp_stall)
    else $error("input stalled with room in pipeline");

  a_read_flag: assert property (@(posedge clk) disable iff (rst)
    a_move && !a_pop |=> rsp.key_code == ksr_pkg::EMPTY_CODE && !rsp.read_valid)
    else $error("non-pop beat carries a code");
`endif

endmodule

/* tb/keypad_result_checker.sv */
// Result checker for the keypad scanner: tracks config writes, predicts each result, compares.
`timescale 1ns / 100ps
module keypad_result_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  input  logic                                req_stall,
  input  ksr_pkg::req_t                       req,
  input  logic                                rsp_valid,
  input  logic                                rsp_stall,
  input  ksr_pkg::rsp_t                       rsp,
  input  logic                                cfg_write,
  input  logic [ksr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [ksr_pkg::CFG_WIDTH-1:0]       cfg_data,
  output int                                  errors,
  output int                                  results_owed
);
  import ksr_pkg::*;

  localparam int ROWS  = ROWS_DEFAULT;
  localparam int COLS  = COLS_DEFAULT;
  localparam int DEPTH = BUFFER_DEPTH_DEFAULT;

  typedef enum logic [1:0] {
    KEY_UP,
    KEY_DEBOUNCE,
    KEY_START_WAIT,
    KEY_REPEAT_WAIT
  } scan_phase_e;

  logic [7:0] start_delay_reg;
  logic [7:0] repeat_delay_reg;
  logic [6:0] shift_one_reg;
  logic [6:0] shift_two_reg;

  scan_phase_e           scan_phase;
  logic [7:0]            start_left;
  logic [7:0]            repeat_left;
  logic [CODE_WIDTH-1:0] key_codes [DEPTH];
  int                    wr_ptr;
  int                    rd_ptr;
  int                    fill;
  rsp_t                  expected_results [$];

  // lowest row with any key down wins, then its lowest column
  function automatic logic [7:0] key_code_of(logic [MATRIX_WIDTH-1:0] matrix,
                                             logic [1:0] shifts);
    int         row;
    int         col;
    logic [7:0] code;
    row = 0;
    col = 0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (((matrix >> (r * COLS)) & ((1 << COLS) - 1)) != 0) begin
        row = r;
        for (int c = COLS - 1; c >= 0; c--) begin
          if (matrix[r * COLS + c]) col = c;
        end
      end
    end
    code = 8'(col + row * COLS);
    if (shifts[0]) code = code + 8'(shift_one_reg);
    if (shifts[1]) code = code + 8'(shift_two_reg);
    return code;
  endfunction

  // a full buffer drops the code
  function automatic void store_code(logic [7:0] code);
    if (fill < DEPTH) begin
      key_codes[wr_ptr] = code;
      wr_ptr = (wr_ptr + 1) % DEPTH;
      fill++;
    end
  endfunction

  function automatic rsp_t predict_key_result(req_t item);
    rsp_t                    res;
    logic [MATRIX_WIDTH-1:0] matrix;
    logic                    down;
    res.read_valid = 1'b0;
    res.key_code   = EMPTY_CODE;
    if (item.mode == MODE_READ) begin
      if (fill > 0) begin
        res.key_code   = key_codes[rd_ptr];
        res.read_valid = 1'b1;
        rd_ptr = (rd_ptr + 1) % DEPTH;
        fill--;
      end
    end else begin
      matrix = item.key_matrix & MATRIX_WIDTH'((1 << (ROWS * COLS)) - 1);
      down   = (matrix != '0);
      case (scan_phase)
        KEY_UP: begin
          if (down) scan_phase = KEY_DEBOUNCE;
        end
        KEY_DEBOUNCE: begin
          if (down) begin
            store_code(key_code_of(matrix, item.shift_keys));
            start_left = start_delay_reg;
            scan_phase = KEY_START_WAIT;
          end else begin
            scan_phase = KEY_UP;
          end
        end
        KEY_START_WAIT: begin
          // a zero countdown never fires
          if (!down) begin
            scan_phase = KEY_DEBOUNCE;
          end else if (start_left != 0) begin
            start_left--;
            if (start_left == 0) begin
              store_code(key_code_of(matrix, item.shift_keys));
              repeat_left = repeat_delay_reg;
              scan_phase  = KEY_REPEAT_WAIT;
            end
          end
        end
        default: begin
          if (!down) begin
            scan_phase = KEY_DEBOUNCE;
          end else if (repeat_left != 0) begin
            repeat_left--;
            if (repeat_left == 0) begin
              store_code(key_code_of(matrix, item.shift_keys));
              repeat_left = repeat_delay_reg;
            end
          end
        end
      endcase
    end
    res.pending_count = PENDING_WIDTH'(fill);
    return res;
  endfunction

  task automatic report_field(string field, logic [7:0] want, logic [7:0] got);
    errors++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      start_delay_reg  = RESET_REPEAT_START_DELAY;
      repeat_delay_reg = RESET_REPEAT_DELAY;
      shift_one_reg    = RESET_SHIFT_ONE_OFFSET;
      shift_two_reg    = RESET_SHIFT_TWO_OFFSET;
      scan_phase       = KEY_UP;
      start_left       = '0;
      repeat_left      = '0;
      wr_ptr           = 0;
      rd_ptr           = 0;
      fill             = 0;
      errors           = 0;
      expected_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_REPEAT_START_DELAY: start_delay_reg = cfg_data;
          REG_REPEAT_DELAY:       repeat_delay_reg = cfg_data;
          REG_SHIFT_ONE_OFFSET:   shift_one_reg = cfg_data[6:0];
          default:                shift_two_reg = cfg_data[6:0];
        endcase
      end
      if (req_valid && !req_stall) expected_results.push_back(predict_key_result(req));
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result beat, expected none, actual %p", $time, rsp);
        end else begin
          want = expected_results.pop_front();
          if (rsp.read_valid !== want.read_valid)
            report_field("read_valid", 8'(want.read_valid), 8'(rsp.read_valid));
          if (rsp.key_code !== want.key_code)
            report_field("key_code", want.key_code, rsp.key_code);
          if (rsp.pending_count !== want.pending_count)
            report_field("pending_count", 8'(want.pending_count), 8'(rsp.pending_count));
        end
      end
    end
    results_owed = expected_results.size();
  end

endmodule

/* tb/tb_top.sv */
// Testbench top for the keypad scanner: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module tb_top;
  import ksr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                       clk;
  logic                       rst;
  logic                       req_valid;
  logic                       req_stall;
  req_t                       req;
  logic                       rsp_valid;
  logic                       rsp_stall;
  rsp_t                       rsp;
  logic                       cfg_write;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0]       cfg_data;
  int                         errors;
  int                         results_owed;

  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_len;
  int phase_items;
  int cycles;

  keypad_scan_repeat_fifo dut (.*);

  keypad_result_checker result_checker (.*);

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_len != 0) begin
        hold_left   = rx_hold_len;
        rx_hold_len = 0;
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  task automatic send_item(logic mode, logic [MATRIX_WIDTH-1:0] matrix, logic [1:0] shifts);
    req_t item;
    item.mode       = mode;
    item.key_matrix = matrix;
    item.shift_keys = shifts;
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    phase_items++;
  endtask

  // stop offering, wait for every result, then let the pipeline settle
  task automatic wait_idle();
    req_valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] start_delay, logic [7:0] rep_delay,
                            logic [6:0] off_one, logic [6:0] off_two);
    cfg_write <= 1'b1;
    cfg_index <= REG_REPEAT_START_DELAY;
    cfg_data  <= start_delay;
    @(posedge clk);
    cfg_index <= REG_REPEAT_DELAY;
    cfg_data  <= rep_delay;
    @(posedge clk);
    cfg_index <= REG_SHIFT_ONE_OFFSET;
    cfg_data  <= {1'b0, off_one};
    @(posedge clk);
    cfg_index <= REG_SHIFT_TWO_OFFSET;
    cfg_data  <= {1'b0, off_two};
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // hold a key (contents may wander), reads mixed in, then release
  task automatic press_episode(int hold);
    logic [MATRIX_WIDTH-1:0] keys;
    logic [1:0]              shifts;
    keys   = MATRIX_WIDTH'($urandom_range(1, 15));
    shifts = 2'($urandom);
    for (int n = 0; n < hold; n++) begin
      if ($urandom_range(99) < 8) keys = MATRIX_WIDTH'($urandom_range(1, 15));
      if ($urandom_range(99) < 10) shifts = 2'($urandom);
      send_item(MODE_TICK, keys, shifts);
      if ($urandom_range(99) < 30) send_item(MODE_READ, MATRIX_WIDTH'($urandom), 2'($urandom));
    end
    // one release tick re-arms debounce, a second drops back to up
    repeat ($urandom_range(1, 3)) send_item(MODE_TICK, '0, 2'($urandom));
  endtask

  task automatic run_phase(int target);
    phase_items = 0;
    while (phase_items < target) begin
      if ($urandom_range(99) < 15) begin
        send_item(1'($urandom), MATRIX_WIDTH'($urandom), 2'($urandom));
      end else if ($urandom_range(99) < 20) begin
        repeat ($urandom_range(1, 20))
          send_item(MODE_READ, MATRIX_WIDTH'($urandom), 2'($urandom));
      end else begin
        press_episode(($urandom_range(99) < 10) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 10));
      end
    end
  endtask

  initial begin
    rst         <= 1'b1;
    req_valid   <= 1'b0;
    req         <= '0;
    cfg_write   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    tx_idle_pct = 22;
    rx_idle_pct = 51;
    rx_hold_len = 0;
    phase_items = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed, reset register values
    send_item(MODE_READ, '0, 2'b00);
    send_item(MODE_TICK, 4'b0000, 2'b11);
    send_item(MODE_TICK, 4'b0001, 2'b00);
    send_item(MODE_TICK, 4'b0001, 2'b00);
    send_item(MODE_TICK, 4'b0000, 2'b00);
    send_item(MODE_TICK, 4'b1000, 2'b11);
    send_item(MODE_TICK, 4'b0110, 2'b01);
    send_item(MODE_TICK, 4'b0000, 2'b00);
    send_item(MODE_TICK, 4'b0000, 2'b10);
    send_item(MODE_TICK, 4'b0100, 2'b10);
    send_item(MODE_TICK, 4'b0100, 2'b10);
    send_item(MODE_TICK, 4'b0000, 2'b00);
    send_item(MODE_TICK, 4'b0000, 2'b00);
    send_item(MODE_READ, 4'b1111, 2'b11);
    send_item(MODE_TICK, 4'b1111, 2'b11);
    send_item(MODE_TICK, 4'b1111, 2'b11);
    send_item(MODE_TICK, 4'b0000, 2'b00);
    send_item(MODE_TICK, 4'b0000, 2'b00);
    repeat (5) send_item(MODE_READ, 4'b0000, 2'b00);

    wait_idle();
    set_config(8'd1, 8'd1, 7'd0, 7'd0);
    rx_hold_len = 150;
    run_phase(70);

    wait_idle();
    set_config(8'd255, 8'd255, 7'd127, 7'd127);
    press_episode(260);
    run_phase(40);

    tx_idle_pct = 51;
    rx_idle_pct = 22;
    wait_idle();
    set_config(8'd0, 8'd0, 7'($urandom), 7'($urandom));
    run_phase(70);

    // bit 3 with both shifts gives a code of 255
    wait_idle();
    set_config(8'd2, 8'd1, 7'd127, 7'd125);
    run_phase(35);
    wait_idle();
    run_phase(35);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    wait_idle();
    set_config(8'($urandom_range(1, 8)), 8'($urandom_range(1, 6)),
               7'($urandom), 7'($urandom));
    run_phase(70);

    wait_idle();
    set_config(8'd3, 8'd3, 7'($urandom), 7'($urandom));
    run_phase(70);

    wait_idle();
    repeat (6) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
